### rtl/core/pbrld_pkg.sv
// ----------------------------------------------------------------------------
// pbrld_pkg
// Shared types and constants for the PackBits run-length decoder.
// ----------------------------------------------------------------------------
package pbrld_pkg;

  localparam int TOTAL_BITS_DEF = 24;  // default width of the running count
  localparam int LANES_DEF      = 4;   // default packing width of a run
  localparam int TOTAL_MAX_W    = 32;  // widest running count allowed
  localparam int NUM_LANES      = 4;   // lanes present on the result word
  localparam int LANE_MAX       = 4;   // packing width is clamped to this
  localparam int BYTE_W         = 8;
  localparam int COUNT_W        = 3;
  localparam int OUT_TOTAL_W    = 24;

  // Decoder phase; EMIT drains a run as packed result words
  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_RUN_VAL = 2'd1,
    ST_LITERAL = 2'd2,
    ST_EMIT    = 2'd3
  } dec_state_t;

  // controller -> datapath
  typedef struct packed {
    logic hdr_load;   // header byte accepted
    logic hdr_final;  // header byte was the last source byte
    logic lit_take;   // literal byte accepted
    logic run_load;   // run value accepted
    logic run_emit;   // emit next packed run word
  } dec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic lit_last;   // current literal byte closes the packet
    logic run_last;   // next run word is the last of the run
  } dec_status_t;

endpackage

### rtl/core/packbits_run_length_decoder.sv
// ----------------------------------------------------------------------------
// packbits_run_length_decoder
// PackBits-style decoder: one compressed byte in, packed decoded words out.
// ----------------------------------------------------------------------------
// Takes one compressed byte per input word, in_final_byte marking the last
// byte of a source stream. A header h (signed) below zero repeats the next
// byte 1-h times (h = -128 gives 129 copies); h >= 0 copies the next h+1
// bytes literally. Runs come out as words of up to LANES bytes; each literal
// byte comes out as a one-byte word. Every word carries the running decoded
// byte count (out_total, saturating). The word for the final source byte
// has out_stream_done set and out_truncated set if the stream stopped inside
// a packet; a final header byte yields a status word with lane count zero.
// After a final byte all counters return to reset for the next stream.
// Timing: header and literal bytes are taken one per cycle. A run value is
// taken and then holds off input while the packing stage drains the run
// into the output register. Every cycle a word waits on out_stall also
// holds off input and pauses the run drain.
// ----------------------------------------------------------------------------
module packbits_run_length_decoder #(
  parameter int TOTAL_BITS = pbrld_pkg::TOTAL_BITS_DEF,  // 8..32
  parameter int LANES      = pbrld_pkg::LANES_DEF        // 1..8, clamped to 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // compressed input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pbrld_pkg::BYTE_W-1:0]        in_code_byte,
  input  logic                                in_final_byte,
  // decoded output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane0,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane1,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane2,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane3,
  output logic [pbrld_pkg::COUNT_W-1:0]       out_lane_count,
  output logic                                out_run_last,
  output logic                                out_stream_done,
  output logic [pbrld_pkg::OUT_TOTAL_W-1:0]   out_total,
  output logic                                out_truncated
);
  import pbrld_pkg::*;

  dec_cmd_t    cmd;     // phase FSM -> datapath
  dec_status_t status;  // datapath -> phase FSM

  // phase sequencer: header / run value / literal / run drain
  pbrld_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_sign       (in_code_byte[BYTE_W-1]),
    .in_final_byte (in_final_byte),
    .status        (status),
    .cmd           (cmd),
    .in_stall      (in_stall)
  );

  // counters, run packer, byte count and output word register
  pbrld_dp #(
    .TOTAL_BITS (TOTAL_BITS),
    .LANES      (LANES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_code_byte    (in_code_byte),
    .in_final_byte   (in_final_byte),
    .out_stall       (out_stall),
    .status          (status),
    .out_valid       (out_valid),
    .out_lane0       (out_lane0),
    .out_lane1       (out_lane1),
    .out_lane2       (out_lane2),
    .out_lane3       (out_lane3),
    .out_lane_count  (out_lane_count),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done),
    .out_total       (out_total),
    .out_truncated   (out_truncated)
  );

endmodule

### rtl/core/pbrld_ctrl.sv
// ----------------------------------------------------------------------------
// pbrld_ctrl
// Phase state machine: steers the datapath and drives the input stall.
// ----------------------------------------------------------------------------
module pbrld_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_sign,
  input  logic                   in_final_byte,
  input  pbrld_pkg::dec_status_t status,
  output pbrld_pkg::dec_cmd_t    cmd,
  output logic                   in_stall
);
  import pbrld_pkg::*;

  dec_state_t state_r;
  dec_state_t state_nxt;
  logic       accept;

  assign in_stall = (state_r == ST_EMIT) || !status.out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HEADER: begin
        if (accept) begin
          cmd.hdr_load = 1'b1;
          if (in_final_byte) begin
            cmd.hdr_final = 1'b1;
          end else if (in_sign) begin
            state_nxt = ST_RUN_VAL;
          end else begin
            state_nxt = ST_LITERAL;
          end
        end
      end
      ST_LITERAL: begin
        if (accept) begin
          cmd.lit_take = 1'b1;
          if (in_final_byte || status.lit_last) begin
            state_nxt = ST_HEADER;
          end
        end
      end
      ST_RUN_VAL: begin
        if (accept) begin
          cmd.run_load = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.run_emit = 1'b1;
          if (status.run_last) begin
            state_nxt = ST_HEADER;
          end
        end
      end
      default: begin
        state_nxt = ST_HEADER;
      end
    endcase
  end

endmodule

### rtl/core/pbrld_dp.sv
// ----------------------------------------------------------------------------
// pbrld_dp
// Counters, run packing, saturating byte count and the output word register.
// ----------------------------------------------------------------------------
module pbrld_dp #(
  parameter int TOTAL_BITS = pbrld_pkg::TOTAL_BITS_DEF,
  parameter int LANES      = pbrld_pkg::LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pbrld_pkg::dec_cmd_t                 cmd,
  input  logic [pbrld_pkg::BYTE_W-1:0]        in_code_byte,
  input  logic                                in_final_byte,
  input  logic                                out_stall,
  output pbrld_pkg::dec_status_t              status,
  output logic                                out_valid,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane0,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane1,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane2,
  output logic [pbrld_pkg::BYTE_W-1:0]        out_lane3,
  output logic [pbrld_pkg::COUNT_W-1:0]       out_lane_count,
  output logic                                out_run_last,
  output logic                                out_stream_done,
  output logic [pbrld_pkg::OUT_TOTAL_W-1:0]   out_total,
  output logic                                out_truncated
);
  import pbrld_pkg::*;

  // effective packing width, clamped to the lanes that exist
  localparam int LW = (LANES > LANE_MAX) ? LANE_MAX : ((LANES < 1) ? 1 : LANES);

  // stream state
  logic [BYTE_W-1:0]     literal_left_r, literal_left_nxt;
  logic [BYTE_W-1:0]     run_left_r, run_left_nxt;
  logic [BYTE_W-1:0]     run_byte_r, run_byte_nxt;
  logic                  run_fin_r, run_fin_nxt;
  logic [TOTAL_BITS-1:0] byte_total_r, byte_total_nxt;

  // output word
  logic                             out_valid_r, out_valid_nxt;
  logic [NUM_LANES-1:0][BYTE_W-1:0] lanes_r, lanes_nxt;
  logic [COUNT_W-1:0]               count_r, count_nxt;
  logic                             last_r, last_nxt;
  logic                             done_r, done_nxt;
  logic [OUT_TOTAL_W-1:0]           total_r, total_nxt;
  logic                             trunc_r, trunc_nxt;

  logic [COUNT_W-1:0]    chunk;
  logic [COUNT_W-1:0]    add_n;
  logic [TOTAL_BITS:0]   sum;
  logic [TOTAL_BITS-1:0] tot_sat;
  logic [TOTAL_BITS-1:0] tot_pick;
  logic [TOTAL_MAX_W-1:0] tot_ext;
  logic                  run_end;

  assign status.out_free = !out_valid_r || !out_stall;
  assign status.lit_last = (literal_left_r == BYTE_W'(1));
  assign status.run_last = (run_left_r <= BYTE_W'(LW));

  assign chunk   = status.run_last ? run_left_r[COUNT_W-1:0] : COUNT_W'(LW);
  assign add_n   = cmd.lit_take ? COUNT_W'(1) : chunk;
  assign sum     = {1'b0, byte_total_r} + (TOTAL_BITS+1)'(add_n);
  assign tot_sat = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
  assign run_end = run_fin_r && status.run_last;

  // reported count is clipped again to the 24-bit field
  assign tot_pick = cmd.hdr_final ? byte_total_r : tot_sat;
  assign tot_ext  = TOTAL_MAX_W'(tot_pick);

  always_comb begin
    literal_left_nxt = literal_left_r;
    run_left_nxt     = run_left_r;
    run_byte_nxt     = run_byte_r;
    run_fin_nxt      = run_fin_r;
    byte_total_nxt   = byte_total_r;
    out_valid_nxt    = out_valid_r && out_stall;
    lanes_nxt        = lanes_r;
    count_nxt        = count_r;
    last_nxt         = last_r;
    done_nxt         = done_r;
    total_nxt        = total_r;
    trunc_nxt        = trunc_r;

    if (cmd.hdr_load || cmd.lit_take || cmd.run_emit) begin
      total_nxt = (|tot_ext[TOTAL_MAX_W-1:OUT_TOTAL_W]) ? '1 : tot_ext[OUT_TOTAL_W-1:0];
    end

    if (cmd.hdr_load) begin
      if (in_code_byte[BYTE_W-1]) begin
        // 1 - h copies, h = byte - 256
        run_left_nxt = BYTE_W'(9'd257 - {1'b0, in_code_byte});
      end else begin
        literal_left_nxt = in_code_byte + BYTE_W'(1);
      end
      if (cmd.hdr_final) begin
        // packet data missing: status-only word, then restart the stream
        out_valid_nxt    = 1'b1;
        lanes_nxt        = '0;
        count_nxt        = '0;
        last_nxt         = 1'b1;
        done_nxt         = 1'b1;
        trunc_nxt        = 1'b1;
        byte_total_nxt   = '0;
        literal_left_nxt = '0;
        run_left_nxt     = '0;
      end
    end

    if (cmd.lit_take) begin
      out_valid_nxt    = 1'b1;
      lanes_nxt        = '0;
      lanes_nxt[0]     = in_code_byte;
      count_nxt        = COUNT_W'(1);
      last_nxt         = 1'b1;
      done_nxt         = in_final_byte;
      trunc_nxt        = in_final_byte && !status.lit_last;
      literal_left_nxt = in_final_byte ? '0 : literal_left_r - BYTE_W'(1);
      byte_total_nxt   = in_final_byte ? '0 : tot_sat;
    end

    if (cmd.run_load) begin
      run_byte_nxt = in_code_byte;
      run_fin_nxt  = in_final_byte;
    end

    if (cmd.run_emit) begin
      out_valid_nxt = 1'b1;
      for (int i = 0; i < NUM_LANES; i++) begin
        lanes_nxt[i] = (COUNT_W'(i) < chunk) ? run_byte_r : '0;
      end
      count_nxt      = chunk;
      last_nxt       = status.run_last;
      done_nxt       = run_end;
      trunc_nxt      = 1'b0;
      run_left_nxt   = run_left_r - BYTE_W'(chunk);
      byte_total_nxt = run_end ? '0 : tot_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literal_left_r <= '0;
      run_left_r     <= '0;
      run_fin_r      <= 1'b0;
      byte_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      literal_left_r <= literal_left_nxt;
      run_left_r     <= run_left_nxt;
      run_fin_r      <= run_fin_nxt;
      byte_total_r   <= byte_total_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    lanes_r    <= lanes_nxt;
    count_r    <= count_nxt;
    last_r     <= last_nxt;
    done_r     <= done_nxt;
    total_r    <= total_nxt;
    trunc_r    <= trunc_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_lane0       = lanes_r[0];
  assign out_lane1       = lanes_r[1];
  assign out_lane2       = lanes_r[2];
  assign out_lane3       = lanes_r[3];
  assign out_lane_count  = count_r;
  assign out_run_last    = last_r;
  assign out_stream_done = done_r;
  assign out_total       = total_r;
  assign out_truncated   = trunc_r;

endmodule

### tb/pbrld_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbrld_sb_pkg
// Scoreboard for the PackBits decoder: predicts decoded words, checks them.
// ----------------------------------------------------------------------------
package pbrld_sb_pkg;

  import pbrld_pkg::*;

  localparam int LANE_W = (LANES_DEF < 1) ? 1 :
                          (LANES_DEF > LANE_MAX) ? LANE_MAX : LANES_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << TOTAL_BITS_DEF) - 64'd1;
  localparam longint unsigned OUT_MAX   = (64'd1 << OUT_TOTAL_W) - 64'd1;

  typedef struct packed {
    logic [NUM_LANES-1:0][BYTE_W-1:0] lanes;  // lanes[0] is lane0
    logic [COUNT_W-1:0]               lane_count;
    logic                             run_last;
    logic                             stream_done;
    logic [OUT_TOTAL_W-1:0]           total;
    logic                             truncated;
  } dec_word_t;

  class rle_scoreboard;
    dec_word_t       decoded_q[$];
    dec_state_t      phase;
    logic [7:0]      literal_left;
    logic [7:0]      repeat_len;
    longint unsigned byte_total;
    int              errors;
    int              words_in;
    int              words_out;
    int              streams_done;

    function new();
      errors       = 0;
      words_in     = 0;
      words_out    = 0;
      streams_done = 0;
      restart();
    endfunction

    function void restart();
      phase        = ST_HEADER;
      literal_left = '0;
      repeat_len   = '0;
      byte_total   = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endfunction

    function void add_count(int unsigned n);
      byte_total += n;
      if (byte_total > COUNT_MAX) byte_total = COUNT_MAX;
    endfunction

    function void push_word(logic [7:0] b, int unsigned cnt, bit last, bit done,
                            bit trunc);
      dec_word_t       w;
      longint unsigned t;
      int              i;
      t = (byte_total > OUT_MAX) ? OUT_MAX : byte_total;
      for (i = 0; i < NUM_LANES; i++) w.lanes[i] = (i < cnt) ? b : '0;
      w.lane_count  = COUNT_W'(cnt);
      w.run_last    = last;
      w.stream_done = done;
      w.total       = OUT_TOTAL_W'(t);
      w.truncated   = trunc;
      decoded_q.push_back(w);
    endfunction

    // one accepted compressed byte -> the words it should produce
    function void decode_byte(logic [7:0] b, logic fin);
      int unsigned left;
      int unsigned c;
      words_in++;
      case (phase)
        ST_RUN_VAL: begin
          left = repeat_len;
          while (left > 0) begin
            c = (left < LANE_W) ? left : LANE_W;
            left -= c;
            add_count(c);
            push_word(b, c, left == 0, fin && left == 0, 1'b0);
          end
          repeat_len = '0;
          phase      = ST_HEADER;
        end
        ST_LITERAL: begin
          literal_left = literal_left - 8'd1;
          add_count(1);
          push_word(b, 1, 1'b1, fin, fin && literal_left != 0);
          if (literal_left == 0) phase = ST_HEADER;
        end
        default: begin
          // unused phase code falls here too
          if (b[7]) begin
            repeat_len = 8'(9'd257 - {1'b0, b});
            phase      = ST_RUN_VAL;
          end else begin
            literal_left = b + 8'd1;
            phase        = ST_LITERAL;
          end
          if (fin) push_word(8'h00, 0, 1'b1, 1'b1, 1'b1);
        end
      endcase
      if (fin) begin
        streams_done++;
        restart();
      end
    endfunction

    function void cmp_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
        report($sformatf("word %0d %s got 0x%0h want 0x%0h", words_out, name, got, want));
    endfunction

    function void check_word(dec_word_t got);
      dec_word_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected", words_out));
      end else begin
        want = decoded_q.pop_front();
        cmp_field("lane0", got.lanes[0], want.lanes[0]);
        cmp_field("lane1", got.lanes[1], want.lanes[1]);
        cmp_field("lane2", got.lanes[2], want.lanes[2]);
        cmp_field("lane3", got.lanes[3], want.lanes[3]);
        cmp_field("lane_count", got.lane_count, want.lane_count);
        cmp_field("run_last", got.run_last, want.run_last);
        cmp_field("stream_done", got.stream_done, want.stream_done);
        cmp_field("total", got.total, want.total);
        cmp_field("truncated", got.truncated, want.truncated);
      end
      words_out++;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void flag_leftover();
      if (decoded_q.size() != 0)
        report($sformatf("%0d decoded words never arrived", decoded_q.size()));
    endfunction
  endclass

endpackage

### tb/tb_packbits_run_length_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packbits_run_length_decoder
// Drives compressed byte streams into the decoder and checks every decoded
// word against a scoreboard prediction, under random idling on both sides.
// ----------------------------------------------------------------------------
// Directed streams hit the header extremes (0x00, 0x7F, 0xFF, 0x80 for a
// 129-byte run), exact and partial lane packing, a final header byte, a
// final byte inside a literal and a final run value. The random part is
// mostly well-formed streams with random content, plus cut-off streams and
// raw noise. A long output hold-off fills the block so it stalls its input.
// ----------------------------------------------------------------------------
module tb_packbits_run_length_decoder;

  import pbrld_pkg::*;
  import pbrld_sb_pkg::*;

  localparam int RAND_WORDS  = 78;       // random input words, roughly
  localparam int HOLD_CYCLES = 300;      // long output hold-off
  localparam int DRAIN_WAIT  = 40;       // settle time once nothing is pending
  localparam int TIMEOUT_NS  = 10000000; // well above the slowest clean run

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_code_byte  = '0;
  logic                   in_final_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [BYTE_W-1:0]      out_lane0;
  logic [BYTE_W-1:0]      out_lane1;
  logic [BYTE_W-1:0]      out_lane2;
  logic [BYTE_W-1:0]      out_lane3;
  logic [COUNT_W-1:0]     out_lane_count;
  logic                   out_run_last;
  logic                   out_stream_done;
  logic [OUT_TOTAL_W-1:0] out_total;
  logic                   out_truncated;

  rle_scoreboard sb = new();

  // {final, byte} words waiting to be sent for the current stream
  logic [8:0] stream_q[$];

  int  words_sent = 0;
  bit  no_idle    = 1'b0;  // quiet stretch: neither side idles
  bit  hold_req   = 1'b0;  // sender asks the receiver for a long hold-off
  int  hold_left  = 0;

  always #10 clk = ~clk;

  packbits_run_length_decoder #(
    .TOTAL_BITS(TOTAL_BITS_DEF),
    .LANES     (LANES_DEF)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_byte   (in_code_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lane0      (out_lane0),
    .out_lane1      (out_lane1),
    .out_lane2      (out_lane2),
    .out_lane3      (out_lane3),
    .out_lane_count (out_lane_count),
    .out_run_last   (out_run_last),
    .out_stream_done(out_stream_done),
    .out_total      (out_total),
    .out_truncated  (out_truncated)
  );

  // ---------------------------------------------------------------------
  // Receiver: stall changes on the falling edge. A hold-off request wins
  // over everything and is counted down here, cycle by cycle.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  // Output monitor: a word moves when valid is high and stall is low.
  always @(posedge clk) begin
    dec_word_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.lanes[0]    = out_lane0;
      got.lanes[1]    = out_lane1;
      got.lanes[2]    = out_lane2;
      got.lanes[3]    = out_lane3;
      got.lane_count  = out_lane_count;
      got.run_last    = out_run_last;
      got.stream_done = out_stream_done;
      got.total       = out_total;
      got.truncated   = out_truncated;
      sb.check_word(got);
    end
  end

  // ---------------------------------------------------------------------
  // Sender: one compressed word per call. Payload changes on the falling
  // edge only; the word counts as taken at the first rising edge with
  // in_stall low, and only then goes to the scoreboard.
  // ---------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_code_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.decode_byte(b, fin);
    words_sent++;
  endtask

  task automatic push(input logic [7:0] b, input logic fin);
    stream_q.push_back({fin, b});
  endtask

  task automatic send_stream();
    logic [8:0] w;
    while (stream_q.size() > 0) begin
      w = stream_q.pop_front();
      send_word(w[7:0], w[8]);
    end
  endtask

  // One packet with random content: a run (2..129 copies) or a literal,
  // literals kept short most of the time.
  task automatic add_packet();
    int len;
    if ($urandom_range(1)) begin
      push(8'($urandom_range(128, 255)), 1'b0);
      push(8'($urandom), 1'b0);
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
      push(8'(len - 1), 1'b0);
      repeat (len) push(8'($urandom), 1'b0);
    end
  endtask

  task automatic add_good_stream();
    repeat ($urandom_range(1, 4)) add_packet();
    stream_q[stream_q.size() - 1][8] = 1'b1;
  endtask

  // Stream cut short: final flag on a header, or inside a literal.
  task automatic add_broken_stream();
    int len;
    int k;
    repeat ($urandom_range(0, 2)) add_packet();
    if ($urandom_range(1)) begin
      push(8'($urandom), 1'b1);
    end else begin
      len = $urandom_range(2, 8);
      k   = $urandom_range(1, len - 1);
      push(8'(len - 1), 1'b0);
      repeat (k - 1) push(8'($urandom), 1'b0);
      push(8'($urandom), 1'b1);
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 4)) push(8'($urandom), ($urandom_range(3) == 0));
  endtask

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int dir_words;
    int kind;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed streams ---
    push(8'h00, 1'b0); push(8'hFF, 1'b0);              // literal of one, 0xFF
    push(8'hFF, 1'b0); push(8'h00, 1'b0);              // two copies of 0x00
    push(8'h80, 1'b0); push(8'hA5, 1'b0);              // 129-copy run
    push(8'hFD, 1'b0); push(8'h3C, 1'b0);              // exactly one full word
    push(8'h02, 1'b0); push(8'h12, 1'b0);              // literal of three,
    push(8'h34, 1'b0); push(8'h56, 1'b1);              //   ends stream cleanly
    push(8'hFC, 1'b0); push(8'h01, 1'b1);              // run of 5 on final byte
    push(8'h10, 1'b1);                                 // final header byte
    push(8'h05, 1'b0); push(8'hAA, 1'b0);              // literal cut short
    push(8'hBB, 1'b1);
    push(8'h7F, 1'b0); push(8'h11, 1'b1);              // widest literal, cut
    push(8'hFE, 1'b0); push(8'hC3, 1'b0);              // 3 copies, open stream
    send_stream();
    dir_words = words_sent;

    // sender pauses until everything from the directed part is out
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // long output hold-off while the sender keeps offering words
    hold_req = 1'b1;

    // --- random streams ---
    while (words_sent < dir_words + RAND_WORDS) begin
      no_idle = (words_sent >= dir_words + 40) && (words_sent < dir_words + 70);
      kind    = $urandom_range(99);
      if (kind < 75)      add_good_stream();
      else if (kind < 90) add_broken_stream();
      else                add_noise();
      send_stream();
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.flag_leftover();

    $display("Covered %0d compressed words in %0d streams, %0d decoded words checked.",
             sb.words_in, sb.streams_done, sb.words_out);
    $display("Included a %0d-cycle output hold-off and a full drain pause.", HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/pbrld_pkg.sv
rtl/core/pbrld_ctrl.sv
rtl/core/pbrld_dp.sv
rtl/core/packbits_run_length_decoder.sv
tb/pbrld_sb_pkg.sv
tb/tb_packbits_run_length_decoder.sv
